// File: sv/button_click_classifier_core_macros.svh
// Assertion macros for the button click classifier checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef BUTTON_CLICK_CLASSIFIER_CORE_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication, ignored while in reset.
`define BCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while in reset.
`define BCC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define BCC_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/bcc_pkg.sv
// Shared types and constants of the button click classifier.
// No dependencies.
package bcc_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int ELAPSED_W      = 16;
    localparam int CFG_W          = 16;
    localparam int EVENT_W        = 2;
    localparam int CFG_IDX_W      = 1;

    typedef logic [EVENT_W-1:0]   t_event;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_event EV_NONE   = 2'd0;
    localparam t_event EV_SINGLE = 2'd1;
    localparam t_event EV_DOUBLE = 2'd2;
    localparam t_event EV_LONG   = 2'd3;

    localparam t_cfg_idx REG_DOUBLE_CLICK_GAP = 1'b0;
    localparam t_cfg_idx REG_LONG_PRESS_LIMIT = 1'b1;

    localparam logic [CFG_W-1:0] GAP_RESET   = 16'd350;
    localparam logic [CFG_W-1:0] LIMIT_RESET = 16'd1000;

    typedef struct packed {
        logic [CFG_W-1:0] double_click_gap;
        logic [CFG_W-1:0] long_press_limit;
    } t_cfg;

endpackage

// File: sv/bcc_in_if.sv
// Sample channel: button level and elapsed milliseconds.
// Depends on bcc_pkg.
interface bcc_in_if;
    import bcc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 button_level;
    logic [ELAPSED_W-1:0] elapsed_ms;

    modport source (output valid, output button_level, output elapsed_ms, input ready);
    modport sink   (input valid, input button_level, input elapsed_ms, output ready);
endinterface

// File: sv/bcc_out_if.sv
// Result channel: classified click event.
// Depends on bcc_pkg.
interface bcc_out_if;
    import bcc_pkg::*;

    logic   valid;
    logic   ready;
    t_event click_event;

    modport source (output valid, output click_event, input ready);
    modport sink   (input valid, input click_event, output ready);
endinterface

// File: sv/bcc_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on bcc_pkg.
interface bcc_cfg_if;
    import bcc_pkg::*;

    logic             valid;
    logic             ready;
    t_cfg_idx         index;
    logic [CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/bcc_cfg_regs.sv
// Configuration registers: double-click gap and long-press limit.
// Depends on bcc_pkg and bcc_cfg_if.
module bcc_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bcc_cfg_if.sink       i_cfg,
    output bcc_pkg::t_cfg o_cfg
);
    import bcc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_DOUBLE_CLICK_GAP: n_cfg.double_click_gap = i_cfg.data;
                REG_LONG_PRESS_LIMIT: n_cfg.long_press_limit = i_cfg.data;
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.double_click_gap <= GAP_RESET;
            r_cfg.long_press_limit <= LIMIT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

// File: sv/bcc_classify.sv
// Button state registers and the per-sample classification logic.
// Depends on bcc_pkg.
module bcc_classify #(
    parameter int TIMER_BITS = bcc_pkg::TIMER_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic                            i_level,
    input  logic [bcc_pkg::ELAPSED_W-1:0]   i_elapsed,
    input  bcc_pkg::t_cfg                   i_cfg,
    output bcc_pkg::t_event                 o_event
);
    import bcc_pkg::*;

    // Compare width covers the timers and the 16-bit limits and deltas.
    localparam int CW0 = (TIMER_BITS > ELAPSED_W) ? TIMER_BITS : ELAPSED_W;
    localparam int CW  = (CW0 > CFG_W) ? CW0 : CFG_W;
    localparam int SW  = CW + 1;

    logic                  r_prev_level;
    logic                  n_prev_level;
    logic [TIMER_BITS-1:0] r_press;
    logic [TIMER_BITS-1:0] n_press;
    logic [TIMER_BITS-1:0] r_release;
    logic [TIMER_BITS-1:0] n_release;
    logic                  r_awaiting;
    logic                  n_awaiting;
    logic [TIMER_BITS-1:0] w_press_sum;
    logic [TIMER_BITS-1:0] w_release_sum;
    t_event                w_event;

    function automatic logic [TIMER_BITS-1:0] sat_add(
        input logic [TIMER_BITS-1:0] t,
        input logic [ELAPSED_W-1:0]  d
    );
        logic [SW-1:0] sum;
        sum = SW'(t) + SW'(d);
        if (|sum[SW-1:TIMER_BITS]) begin
            return {TIMER_BITS{1'b1}};
        end
        return sum[TIMER_BITS-1:0];
    endfunction

    assign w_press_sum   = sat_add(r_press, i_elapsed);
    assign w_release_sum = sat_add(r_release, i_elapsed);

    always_comb begin
        n_prev_level = i_level;
        n_press      = r_press;
        n_release    = r_release;
        n_awaiting   = r_awaiting;
        w_event      = EV_NONE;
        case ({i_level, r_prev_level})
            2'b10: begin
                // press edge: release timer restarts, no press time yet
                n_release = '0;
            end
            2'b01: begin
                if (CW'(r_press) >= CW'(i_cfg.long_press_limit)) begin
                    w_event = EV_LONG;
                end else if (r_awaiting) begin
                    w_event    = EV_DOUBLE;
                    n_awaiting = 1'b0;
                end else begin
                    n_awaiting = 1'b1;
                end
                n_press = '0;
            end
            2'b11: begin
                n_press = w_press_sum;
            end
            default: begin
                n_release = w_release_sum;
                if (r_awaiting && (CW'(w_release_sum) >= CW'(i_cfg.double_click_gap))) begin
                    w_event    = EV_SINGLE;
                    n_awaiting = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b0;
            r_press      <= '0;
            r_release    <= '0;
            r_awaiting   <= 1'b0;
        end else if (i_accept) begin
            r_prev_level <= n_prev_level;
            r_press      <= n_press;
            r_release    <= n_release;
            r_awaiting   <= n_awaiting;
        end
    end

    assign o_event = w_event;
endmodule

// File: sv/bcc_out_stage.sv
// Result register with valid/ready handshake toward the consumer.
// Depends on bcc_pkg and bcc_out_if.
module bcc_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  bcc_pkg::t_event i_event,
    output logic            o_free,
    bcc_out_if.source       o_out
);
    import bcc_pkg::*;

    logic   r_valid;
    logic   n_valid;
    t_event r_event;

    // A new result may load when empty or when the held one transfers now.
    assign o_free = !r_valid || o_out.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_event <= i_event;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.click_event = r_event;
endmodule

// File: sv/button_click_classifier_core.sv
// Button click classifier: turns timed button samples into click events.
// Depends on bcc_pkg, the channel interfaces, bcc_cfg_regs, bcc_classify, bcc_out_stage.
//
// Every accepted sample (button level plus milliseconds since the previous sample)
// produces exactly one click_event (none, single, double or long), presented in the cycle
// after the sample transfers. A sample can transfer every cycle: the press/release
// timers and the pending-click flag are updated in a single pass between the sample
// transfer and the result register. The input is back-pressured only while a result
// is held in the output register and the consumer is not ready. Timers are
// TIMER_BITS wide and saturate. Configuration writes are always ready and take
// effect on the next sample; write them while no sample is in flight.
module button_click_classifier_core #(
    parameter int TIMER_BITS = bcc_pkg::TIMER_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bcc_in_if.sink    i_in,
    bcc_cfg_if.sink   i_cfg,
    bcc_out_if.source o_out
);
    import bcc_pkg::*;

    t_cfg   w_cfg;
    t_event w_event;
    logic   w_free;
    logic   w_accept;

    assign i_in.ready = w_free;
    assign w_accept   = i_in.valid && w_free;

    bcc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    bcc_classify #(
        .TIMER_BITS (TIMER_BITS)
    ) u_classify (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_level   (i_in.button_level),
        .i_elapsed (i_in.elapsed_ms),
        .i_cfg     (w_cfg),
        .o_event   (w_event)
    );

    bcc_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept),
        .i_event (w_event),
        .o_free  (w_free),
        .o_out   (o_out)
    );
endmodule

// File: sv/bcc_checker.sv
// Port-level checks for the button click classifier, bound to the top level.
// Depends on bcc_pkg and button_click_classifier_core_macros.svh.
`include "button_click_classifier_core_macros.svh"

module bcc_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input bcc_pkg::t_event i_click_event
);
    import bcc_pkg::*;

    // every sample transfer yields a result in the next cycle
    `BCC_ASSERT_NXT(a_sample_gives_result, i_in_valid && i_in_ready, i_out_valid, "missing result")
    // a stalled result blocks new samples
    `BCC_ASSERT_IMP(a_stall_blocks_input, i_out_valid && !i_out_ready, !i_in_ready, "ready while stalled")
    `BCC_ASSERT_RST(a_reset_empties, !i_rst_n, !i_out_valid, "result valid after reset")
    `BCC_ASSERT_NXT(a_valid_holds, i_out_valid && !i_out_ready, i_out_valid, "result dropped")
    `BCC_ASSERT_NXT(a_event_holds, i_out_valid && !i_out_ready, $stable(i_click_event), "event changed")
endmodule

bind button_click_classifier_core bcc_checker u_bcc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_click_event (o_out.click_event)
);

// File: dv/tb_button_click_classifier_core.sv
// Self-checking testbench for button_click_classifier_core: timed button samples in,
// click events out, compared against a cycle-free model of the timers and click flag.
// Depends on bcc_pkg, bcc_in_if, bcc_out_if, bcc_cfg_if and the core RTL.
module tb_button_click_classifier_core;
    import bcc_pkg::*;

    localparam int TMR_W      = TIMER_BITS_DEF;
    localparam int STALL_CAP  = 2000;
    localparam int RAND_ITEMS = 1050;

    // Models the press/release timers and the pending-click flag; holds the event
    // each accepted sample must produce.
    class click_scoreboard;
        logic [CFG_W-1:0] gap;
        logic [CFG_W-1:0] limit;
        bit               was_pressed;
        logic [TMR_W-1:0] press_ms;
        logic [TMR_W-1:0] release_ms;
        bit               first_click;
        t_event           expected_events[$];
        int               errors;

        function new();
            gap         = GAP_RESET;
            limit       = LIMIT_RESET;
            was_pressed = 1'b0;
            press_ms    = '0;
            release_ms  = '0;
            first_click = 1'b0;
            errors      = 0;
        endfunction

        function logic [TMR_W-1:0] sat_add(logic [TMR_W-1:0] t, logic [ELAPSED_W-1:0] d);
            logic [TMR_W:0] s;
            s = {1'b0, t} + d;
            return s[TMR_W] ? {TMR_W{1'b1}} : s[TMR_W-1:0];
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
            if (idx == REG_DOUBLE_CLICK_GAP)
                gap = val;
            else if (idx == REG_LONG_PRESS_LIMIT)
                limit = val;
        endfunction

        function void note_sample(bit level, logic [ELAPSED_W-1:0] ms);
            t_event ev;
            ev = EV_NONE;
            if (level && !was_pressed) begin
                release_ms = '0;
            end else if (!level && was_pressed) begin
                if (press_ms >= limit) begin
                    ev = EV_LONG;
                end else if (first_click) begin
                    ev          = EV_DOUBLE;
                    first_click = 1'b0;
                end else begin
                    first_click = 1'b1;
                end
                press_ms = '0;
            end else if (level) begin
                press_ms = sat_add(press_ms, ms);
            end else begin
                release_ms = sat_add(release_ms, ms);
                if (first_click && release_ms >= gap) begin
                    ev          = EV_SINGLE;
                    first_click = 1'b0;
                end
            end
            was_pressed = level;
            expected_events.push_back(ev);
        endfunction

        function void check_event(t_event got);
            t_event want;
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected click_event, expected none, actual %0d", $time, got);
                errors++;
            end else begin
                want = expected_events.pop_front();
                if (want !== got) begin
                    $display("%0t: click_event mismatch, expected %0d, actual %0d",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return expected_events.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bcc_in_if  in_if ();
    bcc_cfg_if cfg_if ();
    bcc_out_if out_if ();

    button_click_classifier_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .i_cfg  (cfg_if),
        .o_out  (out_if)
    );

    click_scoreboard sb = new();

    bit in_gaps_on;
    bit out_stalls_on;
    int samples_sent;
    int quiet_cycles;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [ELAPSED_W-1:0] pick_ms();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return ELAPSED_W'($urandom_range(0, 200));
        if (r < 80) return ELAPSED_W'($urandom_range(0, 1500));
        if (r < 92) return ELAPSED_W'($urandom);
        return r[0] ? '1 : '0;
    endfunction

    function automatic logic [CFG_W-1:0] pick_cfg();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return '0;
        if (r < 30) return '1;
        if (r < 80) return CFG_W'($urandom_range(1, 1500));
        return CFG_W'($urandom);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Result-side back-pressure
    initial begin
        int stall_left;
        stall_left   = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
                if (out_stalls_on) stall_left = gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready)
                sb.check_event(out_if.click_event);
            if (cfg_if.valid && cfg_if.ready)
                sb.set_reg(cfg_if.index, cfg_if.data);
            if (in_if.valid && in_if.ready)
                sb.note_sample(in_if.button_level, in_if.elapsed_ms);
        end
    end

    // Watchdog: cycles without any transfer on any channel
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_CAP) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_button_click_classifier_core: FAIL");
        $finish;
    end

    task automatic pause_input(int n);
        repeat (n) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
    endtask

    // Leaves valid high after the transfer; the caller follows with a send or a pause.
    task automatic send_sample(bit level, logic [ELAPSED_W-1:0] ms);
        if (in_gaps_on) pause_input(gap_len());
        @(negedge i_clk);
        in_if.valid        <= 1'b1;
        in_if.button_level <= level;
        in_if.elapsed_ms   <= ms;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        samples_sent++;
    endtask

    task automatic drain();
        pause_input(1);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_config(logic [CFG_W-1:0] gap_val, logic [CFG_W-1:0] limit_val);
        drain();
        if ($urandom_range(0, 1)) begin
            write_reg(REG_DOUBLE_CLICK_GAP, gap_val);
            write_reg(REG_LONG_PRESS_LIMIT, limit_val);
        end else begin
            write_reg(REG_LONG_PRESS_LIMIT, limit_val);
            write_reg(REG_DOUBLE_CLICK_GAP, gap_val);
        end
    endtask

    // Mostly full press/hold/release/wait gestures, some raw noise samples
    task automatic random_gesture();
        int holds;
        int waits;
        if ($urandom_range(0, 99) < 75) begin
            holds = $urandom_range(0, 4);
            waits = $urandom_range(0, 5);
            send_sample(1'b1, pick_ms());
            repeat (holds) send_sample(1'b1, pick_ms());
            send_sample(1'b0, pick_ms());
            repeat (waits) send_sample(1'b0, pick_ms());
        end else begin
            repeat ($urandom_range(1, 4)) send_sample(1'($urandom_range(0, 1)), pick_ms());
        end
    endtask

    initial begin
        int phase;
        int phase_end;
        in_if.valid        = 1'b0;
        in_if.button_level = 1'b0;
        in_if.elapsed_ms   = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = REG_DOUBLE_CLICK_GAP;
        cfg_if.data        = '0;
        in_gaps_on         = 1'b0;
        out_stalls_on      = 1'b0;
        samples_sent       = 0;
        i_rst_n            = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset limits of 350 ms gap and 1000 ms long press
        send_sample(1'b0, 16'd0);
        send_sample(1'b1, 16'hFFFF);    // press edge: time not counted
        send_sample(1'b1, 16'd100);
        send_sample(1'b0, 16'hFFFF);    // release edge: first click pending
        send_sample(1'b0, 16'd349);
        send_sample(1'b0, 16'd1);       // gap reached: single
        send_sample(1'b1, 16'd5);
        send_sample(1'b0, 16'd0);
        send_sample(1'b1, 16'd0);
        send_sample(1'b0, 16'd7);       // second short click: double
        send_sample(1'b1, 16'd0);
        send_sample(1'b0, 16'd0);       // pending again
        send_sample(1'b1, 16'd0);
        send_sample(1'b1, 16'd1000);
        send_sample(1'b0, 16'd0);       // long click keeps the pending flag
        send_sample(1'b0, 16'd350);     // so this reports single

        // Zero gap, limit at the timer max: saturated press still counts as long
        set_config(16'd0, 16'hFFFF);
        send_sample(1'b1, 16'd3);
        send_sample(1'b0, 16'd3);
        send_sample(1'b0, 16'd0);       // zero gap: single right away
        send_sample(1'b1, 16'd0);
        send_sample(1'b1, 16'hFFFF);
        send_sample(1'b1, 16'hFFFF);
        send_sample(1'b0, 16'd0);
        send_sample(1'b0, 16'hFFFF);
        send_sample(1'b0, 16'hFFFF);    // release timer saturates, nothing pending

        // Zero limit: every release is long; gap at max
        set_config(16'hFFFF, 16'd0);
        send_sample(1'b1, 16'd0);
        send_sample(1'b0, 16'd0);

        phase = 0;
        samples_sent = 0;
        while (samples_sent < RAND_ITEMS) begin
            case (phase)
                0: set_config(GAP_RESET, LIMIT_RESET);
                1: set_config(16'hFFFF, 16'hFFFF);
                2: set_config(16'd0, 16'd0);
                default: set_config(pick_cfg(), pick_cfg());
            endcase
            in_gaps_on    = $urandom_range(0, 2) != 0;
            out_stalls_on = $urandom_range(0, 2) != 0;
            phase_end = samples_sent + int'($urandom_range(60, 120));
            while (samples_sent < phase_end) random_gesture();
            phase++;
        end

        drain();
        if (sb.errors == 0)
            $display("tb_button_click_classifier_core: PASS");
        else
            $display("tb_button_click_classifier_core: FAIL");
        $finish;
    end

endmodule
